// ----- src/sli_pkg.sv -----
package sli_pkg;

  // Store sizes.
  localparam int LIST_CAPACITY = 64;
  localparam int LOG_CAPACITY  = 64;

  // Address and count widths derived from the store sizes.
  localparam int LIST_AW = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
  localparam int LIST_CW = $clog2(LIST_CAPACITY + 1);
  localparam int LOG_AW  = (LOG_CAPACITY > 1) ? $clog2(LOG_CAPACITY) : 1;
  localparam int LOG_CW  = $clog2(LOG_CAPACITY + 1);

  // Fixed field widths of the item interface.
  localparam int VALUE_W = 32;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;

  typedef enum logic [1:0] {
    OP_INSERT    = 2'd0,
    OP_REMOVE    = 2'd1,
    OP_READ_LIST = 2'd2,
    OP_READ_LOG  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_BAD_INDEX = 3'd4,
    ST_LOG_FULL  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_INS_SHIFT,
    S_REM_SHIFT,
    S_READ_LIST,
    S_READ_LOG
  } state_t;

  typedef struct packed {
    opcode_t                    opcode;
    logic signed [VALUE_W-1:0]  value;
    logic        [POS_W-1:0]    position;
  } request_t;

  typedef struct packed {
    status_t                    status;
    logic signed [VALUE_W-1:0]  read_value;
    logic        [COUNT_W-1:0]  list_count;
    logic        [COUNT_W-1:0]  log_count;
  } response_t;

endpackage

// ----- src/sorted_list_insert_remove_top.sv -----
// Sorted list with removal log. Issue an item by raising start while busy is
// low; the item is taken at that clock edge. Exactly one result comes back per
// item, on response while done is high for a single cycle, and it must be taken
// then: there is no way to hold it off. The list lives in a memory with one read
// port and one write port that is walked one entry per cycle. An insert scans up
// to its slot and then moves the tail down by one entry, writing the new value
// last. A remove scans to the first match and pulls the tail up. Reads of the
// list or the log pass through a read state before done, and rejected items
// (full, empty, bad index) answer in the cycle after they are taken. No new item
// is taken while busy is high. Memory contents are undefined after reset, but
// only entries that have been written can ever be read back.
module sorted_list_insert_remove_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  sli_pkg::request_t     request,
  output logic                  busy,
  output logic                  done,
  output sli_pkg::response_t    response
);

  // Control and payload registers.
  sli_pkg::state_t                    state, state_next;
  sli_pkg::opcode_t                   op;
  logic signed [sli_pkg::VALUE_W-1:0] value;
  logic [sli_pkg::LIST_CW-1:0]        idx, idx_next;
  logic [sli_pkg::LIST_CW-1:0]        slot, slot_next;
  logic [sli_pkg::LIST_CW-1:0]        entry_count, entry_count_next;
  logic [sli_pkg::LOG_CW-1:0]         log_fill, log_fill_next;
  logic                               done_next;
  sli_pkg::response_t                 response_next;

  // Memories.
  logic signed [sli_pkg::VALUE_W-1:0] list_mem [sli_pkg::LIST_CAPACITY];
  logic signed [sli_pkg::VALUE_W-1:0] log_mem  [sli_pkg::LOG_CAPACITY];
  logic signed [sli_pkg::VALUE_W-1:0] list_rdata;
  logic signed [sli_pkg::VALUE_W-1:0] log_rdata;
  logic [sli_pkg::LIST_AW-1:0]        list_raddr;
  logic [sli_pkg::LIST_AW-1:0]        list_waddr;
  logic signed [sli_pkg::VALUE_W-1:0] list_wdata;
  logic                               list_we;
  logic                               log_we;

  logic                               accept;
  logic [sli_pkg::LIST_CW-1:0]        idx_plus1;
  logic [sli_pkg::LIST_CW-1:0]        idx_minus2;
  logic [sli_pkg::LIST_CW-1:0]        count_minus1;

  assign busy         = (state != sli_pkg::S_IDLE);
  assign accept       = start && !busy;
  assign idx_plus1    = idx + sli_pkg::LIST_CW'(1);
  assign idx_minus2   = idx - sli_pkg::LIST_CW'(2);
  assign count_minus1 = entry_count - sli_pkg::LIST_CW'(1);

  // List memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (list_we) begin
      list_mem[list_waddr] <= list_wdata;
    end
    list_rdata <= list_mem[list_raddr];
  end

  // Log memory: appended at the fill point, read at the requested position.
  always_ff @(posedge clk) begin
    if (log_we) begin
      log_mem[log_fill[sli_pkg::LOG_AW-1:0]] <= value;
    end
    log_rdata <= log_mem[sli_pkg::LOG_AW'(request.position)];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sli_pkg::S_IDLE;
      entry_count <= '0;
      log_fill    <= '0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      log_fill    <= log_fill_next;
      done        <= done_next;
    end
  end

  // Payload and sequencing registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= request.opcode;
      value <= request.value;
    end
    idx      <= idx_next;
    slot     <= slot_next;
    response <= response_next;
  end

  // Sequencer: scan, shift and finish one item.
  always_comb begin
    state_next       = state;
    idx_next         = idx;
    slot_next        = slot;
    entry_count_next = entry_count;
    log_fill_next    = log_fill;
    done_next        = 1'b0;
    list_we          = 1'b0;
    list_waddr       = idx[sli_pkg::LIST_AW-1:0];
    list_wdata       = list_rdata;
    list_raddr       = idx_plus1[sli_pkg::LIST_AW-1:0];
    log_we           = 1'b0;
    response_next            = '0;
    response_next.status     = sli_pkg::ST_OK;
    response_next.list_count = sli_pkg::COUNT_W'(entry_count);
    response_next.log_count  = sli_pkg::COUNT_W'(log_fill);

    unique case (state)
      sli_pkg::S_IDLE: begin
        list_raddr = (request.opcode == sli_pkg::OP_READ_LIST) ?
                     sli_pkg::LIST_AW'(request.position) : '0;
        idx_next   = '0;
        if (accept) begin
          unique case (request.opcode)
            sli_pkg::OP_INSERT: begin
              if (32'(entry_count) >= 32'(sli_pkg::LIST_CAPACITY)) begin
                done_next            = 1'b1;
                response_next.status = sli_pkg::ST_FULL;
              end else if (entry_count == '0) begin
                // Empty list: the value goes straight to the first slot.
                slot_next  = '0;
                state_next = sli_pkg::S_INS_SHIFT;
              end else begin
                state_next = sli_pkg::S_SCAN;
              end
            end
            sli_pkg::OP_REMOVE: begin
              if (entry_count == '0) begin
                done_next            = 1'b1;
                response_next.status = sli_pkg::ST_EMPTY;
              end else begin
                state_next = sli_pkg::S_SCAN;
              end
            end
            sli_pkg::OP_READ_LIST: begin
              if (32'(request.position) >= 32'(entry_count)) begin
                done_next            = 1'b1;
                response_next.status = sli_pkg::ST_BAD_INDEX;
              end else begin
                state_next = sli_pkg::S_READ_LIST;
              end
            end
            sli_pkg::OP_READ_LOG: begin
              if (32'(request.position) >= 32'(log_fill)) begin
                done_next            = 1'b1;
                response_next.status = sli_pkg::ST_BAD_INDEX;
              end else begin
                state_next = sli_pkg::S_READ_LOG;
              end
            end
            default: begin
              state_next = sli_pkg::S_IDLE;
            end
          endcase
        end
      end

      // One entry per cycle: list_rdata holds entry idx, next read is idx + 1.
      sli_pkg::S_SCAN: begin
        if (op == sli_pkg::OP_INSERT) begin
          if (value < list_rdata || idx_plus1 == entry_count) begin
            // Slot found; start moving the tail from the last entry.
            slot_next  = (value < list_rdata) ? idx : entry_count;
            idx_next   = entry_count;
            list_raddr = count_minus1[sli_pkg::LIST_AW-1:0];
            state_next = sli_pkg::S_INS_SHIFT;
          end else begin
            idx_next = idx_plus1;
          end
        end else begin
          if (list_rdata == value) begin
            // Match at idx; entry idx + 1 is already being read.
            state_next = sli_pkg::S_REM_SHIFT;
          end else if (idx_plus1 == entry_count) begin
            done_next            = 1'b1;
            response_next.status = sli_pkg::ST_NOT_FOUND;
            state_next           = sli_pkg::S_IDLE;
          end else begin
            idx_next = idx_plus1;
          end
        end
      end

      // Move entries down by one, last first; list_rdata holds entry idx - 1.
      sli_pkg::S_INS_SHIFT: begin
        list_we = 1'b1;
        if (idx == slot) begin
          list_wdata               = value;
          entry_count_next         = entry_count + sli_pkg::LIST_CW'(1);
          done_next                = 1'b1;
          response_next.list_count = sli_pkg::COUNT_W'(entry_count_next);
          state_next               = sli_pkg::S_IDLE;
        end else begin
          list_raddr = idx_minus2[sli_pkg::LIST_AW-1:0];
          idx_next   = idx - sli_pkg::LIST_CW'(1);
        end
      end

      // Pull entries up by one; list_rdata holds entry idx + 1.
      sli_pkg::S_REM_SHIFT: begin
        if (idx_plus1 == entry_count) begin
          entry_count_next         = count_minus1;
          done_next                = 1'b1;
          response_next.read_value = value;
          response_next.list_count = sli_pkg::COUNT_W'(count_minus1);
          if (32'(log_fill) >= 32'(sli_pkg::LOG_CAPACITY)) begin
            response_next.status = sli_pkg::ST_LOG_FULL;
          end else begin
            log_we                  = 1'b1;
            log_fill_next           = log_fill + sli_pkg::LOG_CW'(1);
            response_next.log_count = sli_pkg::COUNT_W'(log_fill_next);
          end
          state_next = sli_pkg::S_IDLE;
        end else begin
          list_we    = 1'b1;
          list_raddr = sli_pkg::LIST_AW'(idx + sli_pkg::LIST_CW'(2));
          idx_next   = idx_plus1;
        end
      end

      sli_pkg::S_READ_LIST: begin
        done_next                = 1'b1;
        response_next.read_value = list_rdata;
        state_next               = sli_pkg::S_IDLE;
      end

      sli_pkg::S_READ_LOG: begin
        done_next                = 1'b1;
        response_next.read_value = log_rdata;
        state_next               = sli_pkg::S_IDLE;
      end

      default: begin
        state_next = sli_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/sli_checker.sv -----
module sli_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input sli_pkg::request_t  request,
  input logic               busy,
  input logic               done,
  input sli_pkg::response_t response
);

  // Every accepted item either answers at once or keeps the block busy.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted item neither answered nor in progress");

  // The block only goes idle by delivering a result.
  assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("block went idle without a result");

  // A full-list refusal reports a list at capacity.
  assert property (@(posedge clk) disable iff (rst)
    (done && response.status == sli_pkg::ST_FULL) |->
      (response.list_count == sli_pkg::COUNT_W'(sli_pkg::LIST_CAPACITY)))
    else $error("full status with list below capacity");

  // A log-full removal reports a log at capacity.
  assert property (@(posedge clk) disable iff (rst)
    (done && response.status == sli_pkg::ST_LOG_FULL) |->
      (response.log_count == sli_pkg::COUNT_W'(sli_pkg::LOG_CAPACITY)))
    else $error("log full status with log below capacity");

endmodule

bind sorted_list_insert_remove_top sli_checker u_sli_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .request  (request),
  .busy     (busy),
  .done     (done),
  .response (response)
);
